FILE: sv/rgbhsl_pkg.sv
// Shared types, constants and width helpers for the RGB to HSL converter.
package rgbhsl_pkg;

	localparam int CHANNEL_BITS      = 8;
	localparam int HUE_BITS          = 13;
	localparam int HUE_FRAC_BITS_DEF = 4;
	localparam int DEN_BITS          = CHANNEL_BITS + 1;

	localparam longint CMAX = (longint'(1) << CHANNEL_BITS) - 1;

	// 2*CMAX*d + den, d and den at most CMAX
	localparam int SAT_NUM_BITS = $clog2((2 * CMAX + 1) * CMAX + 1);

	typedef logic [CHANNEL_BITS-1:0] chan_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_BITS-1:0] hue;
		chan_t               saturation;
		chan_t               lightness;
	} hsl_t;

	function automatic int hue_full(int hf);
		return 360 << hf;
	endfunction

	function automatic int quo_bits(int hf);
		int hw;
		hw = $clog2(hue_full(hf) + 1);
		return (hw > CHANNEL_BITS) ? hw : CHANNEL_BITS;
	endfunction

	// 2*hue_sixth*num + d, num at most 6*d
	function automatic int hue_num_bits(int hf);
		return $clog2((2 * longint'(hue_full(hf)) + 1) * CMAX + 1);
	endfunction

endpackage

FILE: sv/rgbhsl_prep.sv
// Front end: min/max, sector, lightness and divider operands, four stages.
module rgbhsl_prep #(
	parameter int HUE_FRAC_BITS = rgbhsl_pkg::HUE_FRAC_BITS_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  in_valid,
	input  rgbhsl_pkg::pixel_t                                    pixel,
	output logic                                                  out_valid,
	output logic                                                  grey,
	output rgbhsl_pkg::chan_t                                     lightness,
	output logic [rgbhsl_pkg::hue_num_bits(HUE_FRAC_BITS)-1:0]    hue_num,
	output logic [rgbhsl_pkg::DEN_BITS-1:0]                       hue_den,
	output logic [rgbhsl_pkg::SAT_NUM_BITS-1:0]                   sat_num,
	output logic [rgbhsl_pkg::DEN_BITS-1:0]                       sat_den
);
	import rgbhsl_pkg::*;

	localparam int     HNW        = hue_num_bits(HUE_FRAC_BITS);
	localparam int     DIFF_W     = CHANNEL_BITS + 3;
	localparam longint HUE_SIXTH2 = longint'(120) << HUE_FRAC_BITS;

	typedef enum logic [1:0] {SECT_RED, SECT_GREEN, SECT_BLUE} sect_t;

	// stage 1
	logic   v_s1;
	pixel_t pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixel;
	end

	// stage 2
	chan_t                 hi, lo;
	sect_t                 sect;
	logic                  v_s2, grey_s2;
	pixel_t                pix_s2;
	logic [CHANNEL_BITS:0] sum_s2;
	chan_t                 d_s2;
	sect_t                 sect_s2;

	always_comb begin
		hi = pix_s1.red;
		lo = pix_s1.red;
		if (pix_s1.green > hi) hi = pix_s1.green;
		if (pix_s1.blue > hi)  hi = pix_s1.blue;
		if (pix_s1.green < lo) lo = pix_s1.green;
		if (pix_s1.blue < lo)  lo = pix_s1.blue;
		if (hi == pix_s1.red)        sect = SECT_RED;
		else if (hi == pix_s1.green) sect = SECT_GREEN;
		else                         sect = SECT_BLUE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		pix_s2  <= pix_s1;
		sum_s2  <= {1'b0, hi} + {1'b0, lo};
		d_s2    <= hi - lo;
		grey_s2 <= (hi == lo);
		sect_s2 <= sect;
	end

	// stage 3
	logic [DIFF_W-1:0]       rx, gx, bx, dx, num;
	logic [DEN_BITS-1:0]     den;
	logic [CHANNEL_BITS+1:0] sum_rnd;
	logic                    v_s3, grey_s3;
	logic [DIFF_W-1:0]       num_s3;
	chan_t                   d_s3, light_s3;
	logic [DEN_BITS-1:0]     den_s3;

	always_comb begin
		rx      = DIFF_W'(pix_s2.red);
		gx      = DIFF_W'(pix_s2.green);
		bx      = DIFF_W'(pix_s2.blue);
		dx      = DIFF_W'(d_s2);
		den     = (longint'(sum_s2) <= CMAX) ? sum_s2 : DEN_BITS'(2 * CMAX) - sum_s2;
		sum_rnd = {1'b0, sum_s2} + 1'b1;
		// modular arithmetic; every sector result is non-negative
		case (sect_s2)
			SECT_RED:   num = (gx >= bx) ? gx - bx : 3'd6 * dx + gx - bx;
			SECT_GREEN: num = 2'd2 * dx + bx - rx;
			default:    num = 3'd4 * dx + rx - gx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		grey_s3  <= grey_s2;
		num_s3   <= num;
		d_s3     <= d_s2;
		den_s3   <= den;
		light_s3 <= sum_rnd[CHANNEL_BITS:1];
	end

	// stage 4: rounded-division operands (2*n + d) / (2*d)
	logic                    v_s4, grey_s4;
	chan_t                   light_s4;
	logic [HNW-1:0]          hue_num_s4;
	logic [DEN_BITS-1:0]     hue_den_s4, sat_den_s4;
	logic [SAT_NUM_BITS-1:0] sat_num_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		grey_s4    <= grey_s3;
		light_s4   <= light_s3;
		hue_num_s4 <= HNW'(num_s3) * HNW'(HUE_SIXTH2) + HNW'(d_s3);
		hue_den_s4 <= {d_s3, 1'b0};
		sat_num_s4 <= SAT_NUM_BITS'(d_s3) * SAT_NUM_BITS'(2 * CMAX) + SAT_NUM_BITS'(den_s3);
		sat_den_s4 <= {den_s3[DEN_BITS-2:0], 1'b0};
	end

	assign out_valid = v_s4;
	assign grey      = grey_s4;
	assign lightness = light_s4;
	assign hue_num   = hue_num_s4;
	assign hue_den   = hue_den_s4;
	assign sat_num   = sat_num_s4;
	assign sat_den   = sat_den_s4;

endmodule

FILE: sv/rgbhsl_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module rgbhsl_div #(
	parameter int NUM_W  = 24,
	parameter int DEN_W  = 9,
	parameter int Q_W    = 13,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);
	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic              v_s    [Q_W];
	logic [CW-1:0]     rem_s  [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [Q_W-1:0]    quo_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		localparam int BIT = Q_W - 1 - k;

		logic              v_in;
		logic [CW-1:0]     rem_in, dsh;
		logic [DEN_W-1:0]  den_in;
		logic [Q_W-1:0]    quo_in;
		logic [SIDE_W-1:0] side_in;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = CW'(num);
			assign den_in  = den;
			assign quo_in  = '0;
			assign side_in = side;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign dsh = CW'(den_in) << BIT;
		assign ge  = (rem_in >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else         v_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? rem_in - dsh : rem_in;
			den_s[k]  <= den_in;
			quo_s[k]  <= quo_in | (Q_W'(ge) << BIT);
			side_s[k] <= side_in;
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign quo       = quo_s[Q_W-1];
	assign side_out  = side_s[Q_W-1];

endmodule

FILE: sv/rgb_to_hsl_converter.sv
// RGB to HSL converter top level: front end, two dividers, output register.
// done is registered: a start transfer runs through the front-end stages, the
// divider stages and the output register, which is set when both dividers are valid.
// Throughput: one pixel per cycle while busy is low; the two pipelined dividers set depth.
// Reset: asynchronous, clears all valid bits; busy is high until the first
// edge after reset release, then stays low. Results cannot be stalled.
module rgb_to_hsl_converter #(
	parameter int HUE_FRAC_BITS = rgbhsl_pkg::HUE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rgbhsl_pkg::pixel_t pixel,
	output logic               busy,
	output logic               done,
	output rgbhsl_pkg::hsl_t   result
);
	import rgbhsl_pkg::*;

	localparam int Q_W = quo_bits(HUE_FRAC_BITS);
	localparam int HNW = hue_num_bits(HUE_FRAC_BITS);
	// sampling ticks from the transfer edge to the edge that takes the result
	localparam int LAT = Q_W + 5;
	localparam logic [Q_W-1:0] HUE_FULL_Q = Q_W'(hue_full(HUE_FRAC_BITS));

	logic ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ready_q <= 1'b0;
		else         ready_q <= 1'b1;
	end

	assign busy = !ready_q;

	logic                    p_valid, p_grey;
	chan_t                   p_light;
	logic [HNW-1:0]          p_hue_num;
	logic [DEN_BITS-1:0]     p_hue_den, p_sat_den;
	logic [SAT_NUM_BITS-1:0] p_sat_num;

	rgbhsl_prep #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && ready_q),
		.pixel     (pixel),
		.out_valid (p_valid),
		.grey      (p_grey),
		.lightness (p_light),
		.hue_num   (p_hue_num),
		.hue_den   (p_hue_den),
		.sat_num   (p_sat_num),
		.sat_den   (p_sat_den)
	);

	logic           h_valid, s_valid, s_grey;
	logic [Q_W-1:0] h_quo, s_quo;
	chan_t          h_light;

	rgbhsl_div #(
		.NUM_W (HNW),
		.DEN_W (DEN_BITS),
		.Q_W   (Q_W),
		.SIDE_W(CHANNEL_BITS)
	) u_hue_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (p_valid),
		.num      (p_hue_num),
		.den      (p_hue_den),
		.side     (p_light),
		.out_valid(h_valid),
		.quo      (h_quo),
		.side_out (h_light)
	);

	rgbhsl_div #(
		.NUM_W (SAT_NUM_BITS),
		.DEN_W (DEN_BITS),
		.Q_W   (Q_W),
		.SIDE_W(1)
	) u_sat_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (p_valid),
		.num      (p_sat_num),
		.den      (p_sat_den),
		.side     (p_grey),
		.out_valid(s_valid),
		.quo      (s_quo),
		.side_out (s_grey)
	);

	logic [Q_W-1:0] hue_wrap;
	logic           done_q;
	hsl_t           res_q;

	// full circle wraps to zero
	assign hue_wrap = (h_quo >= HUE_FULL_Q) ? h_quo - HUE_FULL_Q : h_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= h_valid && s_valid;
	end

	always_ff @(posedge clk) begin
		res_q.hue        <= s_grey ? '0 : HUE_BITS'(hue_wrap);
		res_q.saturation <= s_grey ? '0 : s_quo[CHANNEL_BITS-1:0];
		res_q.lightness  <= h_light;
	end

	assign done   = done_q;
	assign result = res_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, LAT))
		else $error("result strobe does not match transfer latency");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.saturation == '0) |-> (result.hue == '0))
		else $error("grey pixel with nonzero hue");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy raised after reset");

endmodule
